/* src/lbs_pkg.sv */
`default_nettype none
package lbs_pkg;
  localparam int MaxBonesDefault = 256;
  localparam int WordsPerMat = 12;

  typedef enum logic [1:0] {
    CMD_LOAD_INV = 2'd0,
    CMD_LOAD_CUR = 2'd1,
    CMD_LOAD_LOCAL = 2'd2,
    CMD_INFLUENCE = 2'd3
  } cmd_t;

  typedef enum logic [0:0] {
    REG_BONE_COUNT = 1'd0,
    REG_WEIGHT_FLOOR = 1'd1
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_MAC,
    ST_WEIGHT,
    ST_FINAL,
    ST_OUT
  } state_t;

  // Sequencer controls handed to the multiply-accumulate unit
  typedef struct packed {
    logic clear;
    logic enable;
    logic translate;
  } mac_ctl_t;
endpackage
`default_nettype wire

/* src/linear_blend_skinning_top.sv */
`default_nettype none
// Linear blend skinning. For an influence beat that counts, the inverse and
// current palettes are read one row (three words) a cycle from two memories,
// a fetch step plus four rows per matrix, through one shared three-lane
// multiply-accumulate unit, then a weight step. A final influence with a
// nonzero weight total then runs the local transform (one setup step, four
// rows); every final influence then holds its result in the output stage,
// and input is stalled until that beat is taken. Unwritten palette words
// read as garbage.
module linear_blend_skinning_top #(
  parameter int MAX_BONES = lbs_pkg::MaxBonesDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // tdata: command[1:0], bone_index[9:2], element_index[13:10],
  // matrix_value[45:14], pos_x[77:46], pos_y[109:78], pos_z[141:110],
  // weight[157:142], zero pad [159:158]
  input  wire logic [159:0] s_tdata,
  input  wire logic        s_tlast,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // tdata: out_x[31:0], out_y[63:32], out_z[95:64]
  output logic [95:0]      m_tdata,
  // tuser: updated
  output logic             m_tuser,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  import lbs_pkg::*;
  localparam int BoneW = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;
  localparam int Depth = MAX_BONES * 4;
  localparam int AddrW = $clog2(Depth);

  logic [8:0]  bone_count;
  logic [15:0] weight_floor;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      bone_count <= 9'd0;
      weight_floor <= 16'd7;
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        REG_BONE_COUNT: bone_count <= cfg_data[8:0];
        REG_WEIGHT_FLOOR: weight_floor <= cfg_data;
        default: ;
      endcase
    end
  end

  // Unpack input beat
  logic [1:0]  in_cmd;
  logic [7:0]  in_bone;
  logic [3:0]  in_elem;
  logic [31:0] in_word;
  logic [15:0] in_w;
  assign in_cmd  = s_tdata[1:0];
  assign in_bone = s_tdata[9:2];
  assign in_elem = s_tdata[13:10];
  assign in_word = s_tdata[45:14];
  assign in_w    = s_tdata[157:142];

  // Palettes: one memory row holds one matrix row of three words
  logic [95:0] inv_mem [Depth];
  logic [95:0] cur_mem [Depth];
  logic [31:0] loc_mem [WordsPerMat];
  logic [95:0] inv_rd, cur_rd;
  logic [AddrW-1:0] rd_addr;
  logic [1:0] row_idx;
  logic [1:0] wr_row;
  logic [1:0] wr_col;
  logic [AddrW-1:0] wr_addr;
  logic bone_ok_load;

  state_t state, state_next;
  logic s_acc;
  assign s_acc = s_tvalid && s_tready;

  assign wr_row = in_elem >= 4'd9 ? 2'd3 : in_elem >= 4'd6 ? 2'd2 :
                  in_elem >= 4'd3 ? 2'd1 : 2'd0;
  assign wr_col = 2'(in_elem - 4'(wr_row) * 4'd3);
  assign bone_ok_load = 32'(in_bone) < 32'(MAX_BONES);
  assign wr_addr = AddrW'({32'(in_bone), 2'b00} + 34'(wr_row));

  // Write palette words in place by column
  always_ff @(posedge clk) begin
    if (s_acc && in_elem < 4'(WordsPerMat)) begin
      if (in_cmd == CMD_LOAD_LOCAL) loc_mem[in_elem] <= in_word;
      else if (in_cmd == CMD_LOAD_INV && bone_ok_load)
        inv_mem[wr_addr][wr_col*32 +: 32] <= in_word;
      else if (in_cmd == CMD_LOAD_CUR && bone_ok_load)
        cur_mem[wr_addr][wr_col*32 +: 32] <= in_word;
    end
    inv_rd <= inv_mem[rd_addr];
    cur_rd <= cur_mem[rd_addr];
  end

  // Per-influence registers
  logic [BoneW-1:0] bone;
  logic [31:0] px, py, pz;
  logic [15:0] w;
  logic last, counted;
  logic pass;           // 0 inverse, 1 current
  logic [2:0] step;     // rows issued
  logic signed [63:0] sum_x, sum_y, sum_z;
  logic [31:0] wtot;
  logic [31:0] vx, vy, vz;

  assign rd_addr = AddrW'({32'(bone), 2'b00} + 34'(row_idx));
  assign row_idx = step[1:0];

  // MAC inputs
  mac_ctl_t ctl;
  logic signed [31:0] ma, m0, m1, m2, r0, r1, r2;
  logic [1:0] arow;   // row being accumulated
  always_comb begin
    arow = 2'(step - 3'd1);
    case (arow)
      2'd0: ma = vx;
      2'd1: ma = vy;
      2'd2: ma = vz;
      default: ma = '0;
    endcase
    if (state == ST_FINAL) begin
      m0 = loc_mem[4'(arow) * 4'd3];
      m1 = loc_mem[4'(arow) * 4'd3 + 4'd1];
      m2 = loc_mem[4'(arow) * 4'd3 + 4'd2];
    end else if (pass) begin
      m0 = cur_rd[31:0]; m1 = cur_rd[63:32]; m2 = cur_rd[95:64];
    end else begin
      m0 = inv_rd[31:0]; m1 = inv_rd[63:32]; m2 = inv_rd[95:64];
    end
  end

  lbs_mac u_mac (
    .clk(clk), .ctl(ctl), .a(ma), .m0(m0), .m1(m1), .m2(m2),
    .r0(r0), .r1(r1), .r2(r2)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:
        if (s_acc && in_cmd == CMD_INFLUENCE) begin
          if (in_w >= weight_floor && {1'b0, in_bone} < bone_count &&
              32'(in_bone) < 32'(MAX_BONES)) state_next = ST_FETCH;
          else if (s_tlast) state_next = ST_FINAL;
        end
      ST_FETCH: state_next = ST_MAC;
      ST_MAC:
        if (step == 3'd4) state_next = pass ? ST_WEIGHT : ST_FETCH;
      ST_WEIGHT: state_next = last ? ST_FINAL : ST_IDLE;
      ST_FINAL: if (step == 3'd4 || !counted) state_next = ST_OUT;
      ST_OUT: if (m_tready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    ctl.clear = (state == ST_FETCH) || (state == ST_WEIGHT);
    ctl.enable = (state == ST_MAC) || (state == ST_FINAL && step != 3'd0);
    ctl.translate = (arow == 2'd3);
    s_tready = (state == ST_IDLE) && !m_tvalid;
    m_tvalid = (state == ST_OUT);
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      sum_x <= '0; sum_y <= '0; sum_z <= '0;
      wtot <= '0;
      step <= '0;
      pass <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        ST_IDLE:
          if (s_acc && in_cmd == CMD_INFLUENCE) begin
            bone <= BoneW'(in_bone);
            px <= s_tdata[77:46]; py <= s_tdata[109:78]; pz <= s_tdata[141:110];
            if (state_next == ST_FINAL) begin
              vx <= sum_x[47:16]; vy <= sum_y[47:16]; vz <= sum_z[47:16];
            end else begin
              vx <= s_tdata[77:46]; vy <= s_tdata[109:78]; vz <= s_tdata[141:110];
            end
            w <= in_w; last <= s_tlast; pass <= 1'b0;
            step <= 3'd0;
            counted <= wtot != 32'd0;
          end
        ST_FETCH: begin
          step <= 3'd1;
          // Take the finished inverse-pose result as the second pass input
          if (pass) begin
            vx <= r0; vy <= r1; vz <= r2;
          end
        end
        ST_MAC: begin
          if (step == 3'd4) begin
            step <= 3'd0;
            pass <= 1'b1;
          end else step <= step + 3'd1;
        end
        ST_WEIGHT: begin
          logic signed [63:0] nx, ny, nz;
          logic [31:0] nt;
          nx = sum_x + 64'(signed'(r0)) * 64'(signed'({16'd0, w}));
          ny = sum_y + 64'(signed'(r1)) * 64'(signed'({16'd0, w}));
          nz = sum_z + 64'(signed'(r2)) * 64'(signed'({16'd0, w}));
          nt = wtot + 32'(w);
          sum_x <= nx; sum_y <= ny; sum_z <= nz; wtot <= nt;
          vx <= nx[47:16]; vy <= ny[47:16]; vz <= nz[47:16];
          counted <= nt != 32'd0;
          step <= 3'd0;
        end
        ST_FINAL: step <= step + 3'd1;
        ST_OUT:
          if (m_tready) begin
            sum_x <= '0; sum_y <= '0; sum_z <= '0; wtot <= '0;
          end
        default: ;
      endcase
    end
  end

  // Output beat held until taken
  assign m_tdata = counted ? {r2, r1, r0} : {pz, py, px};
  assign m_tuser = counted;

`ifndef ASSERT_OFF
  a_no_in_while_out: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready) else $error("input taken while result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid) else $error("result dropped");
  a_clear_after_out: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready |=> wtot == 32'd0) else $error("weight total kept");
`endif
endmodule
`default_nettype wire

/* src/lbs_mac.sv */
`default_nettype none
// Three-lane multiply-accumulate: one matrix row per call, one product or shifted translation word per lane.
module lbs_mac (
  input  wire logic                   clk,
  input  wire lbs_pkg::mac_ctl_t      ctl,
  input  wire logic signed [31:0]     a,
  input  wire logic signed [31:0]     m0,
  input  wire logic signed [31:0]     m1,
  input  wire logic signed [31:0]     m2,
  output logic signed [31:0]          r0,
  output logic signed [31:0]          r1,
  output logic signed [31:0]          r2
);
  import lbs_pkg::*;
  logic signed [63:0] acc0, acc1, acc2;
  logic signed [63:0] t0, t1, t2;

  // Form products, or shifted translation words
  always_comb begin
    if (ctl.translate) begin
      t0 = {{16{m0[31]}}, m0, 16'd0};
      t1 = {{16{m1[31]}}, m1, 16'd0};
      t2 = {{16{m2[31]}}, m2, 16'd0};
    end else begin
      t0 = 64'(a) * 64'(m0);
      t1 = 64'(a) * 64'(m1);
      t2 = 64'(a) * 64'(m2);
    end
  end

  // Accumulate
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      acc0 <= '0; acc1 <= '0; acc2 <= '0;
    end else if (ctl.enable) begin
      acc0 <= acc0 + t0; acc1 <= acc1 + t1; acc2 <= acc2 + t2;
    end
  end

  assign r0 = acc0[47:16];
  assign r1 = acc1[47:16];
  assign r2 = acc2[47:16];
endmodule
`default_nettype wire
